/* design/tbp_pkg.sv */
// Shared types, constants and helpers for the tournament branch predictor.
// No dependencies; used by the controller, datapath and top level.
package tbp_pkg;

    // Default table sizes (index widths)
    localparam int PC_INDEX_BITS_DEF    = 14;
    localparam int LOCAL_HIST_BITS_DEF  = 14;
    localparam int GLOBAL_HIST_BITS_DEF = 14;

    // Stream widths
    localparam int PC_W      = 32;
    localparam int S_TDATA_W = 40;  // pc, outcome, zero pad
    localparam int M_TDATA_W = 8;   // four result flags, zero pad

    // Operation codes (s_tuser)
    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_TRAIN   = 1'b1;

    // Counter reset values
    localparam logic [1:0] CTR_STRONG_NT      = 2'd0;
    localparam logic [1:0] CHOOSER_WEAK_LOCAL = 2'd1;

    // Controller states
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP,
        ST_UPDATE
    } tbp_state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic clear;   // write reset values at the sweep address
        logic accept;  // a request is taken this cycle
        logic lookup;  // read the counter and chooser tables
        logic commit;  // load the result and write back training state
    } tbp_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic clear_last;  // last sweep address
        logic out_free;    // result register can take a new result
    } tbp_status_t;

    // 2-bit saturating step toward up (1) or down (0)
    function automatic logic [1:0] sat_step(input logic [1:0] v, input logic up);
        logic [1:0] r;
        r = v;
        if (up) begin
            if (v != 2'd3) r = v + 2'd1;
        end else begin
            if (v != 2'd0) r = v - 2'd1;
        end
        return r;
    endfunction

endpackage

/* design/tbp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module tbp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 16384
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // read port, data held between reads
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* design/tbp_ctrl.sv */
// Controller state machine for the tournament branch predictor.
// Depends on tbp_pkg (state type, command and status structs).
module tbp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  tbp_pkg::tbp_status_t status,
    output tbp_pkg::tbp_cmd_t    cmd
);

    tbp_pkg::tbp_state_t state_reg, state_next;
    logic                accept;

    // request handshake
    always_comb begin
        s_tready = (state_reg == tbp_pkg::ST_IDLE) ||
                   ((state_reg == tbp_pkg::ST_UPDATE) && status.out_free);
        accept   = s_tvalid && s_tready;
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tbp_pkg::ST_CLEAR: begin
                if (status.clear_last) state_next = tbp_pkg::ST_IDLE;
            end
            tbp_pkg::ST_IDLE: begin
                if (accept) state_next = tbp_pkg::ST_LOOKUP;
            end
            tbp_pkg::ST_LOOKUP: begin
                state_next = tbp_pkg::ST_UPDATE;
            end
            tbp_pkg::ST_UPDATE: begin
                if (status.out_free) begin
                    state_next = accept ? tbp_pkg::ST_LOOKUP : tbp_pkg::ST_IDLE;
                end
            end
            default: state_next = tbp_pkg::ST_CLEAR;
        endcase
    end

    // commands
    always_comb begin
        cmd        = '0;
        cmd.accept = accept;
        unique case (state_reg)
            tbp_pkg::ST_CLEAR:  cmd.clear  = 1'b1;
            tbp_pkg::ST_IDLE:   cmd.clear  = 1'b0;
            tbp_pkg::ST_LOOKUP: cmd.lookup = 1'b1;
            tbp_pkg::ST_UPDATE: cmd.commit = status.out_free;
            default:            cmd.clear  = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbp_pkg::ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

/* design/tbp_dpath.sv */
// Datapath: history and counter tables, global history, result register.
// Depends on tbp_pkg and tbp_ram.
module tbp_dpath #(
    parameter int PC_INDEX_BITS    = tbp_pkg::PC_INDEX_BITS_DEF,
    parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
    parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tbp_pkg::tbp_cmd_t             cmd,
    output tbp_pkg::tbp_status_t          status,
    input  logic                          in_operation,
    input  logic [tbp_pkg::PC_W-1:0]      in_pc,
    input  logic                          in_outcome,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tbp_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int CLR_A    = (PC_INDEX_BITS > LOCAL_HIST_BITS) ?
                              PC_INDEX_BITS : LOCAL_HIST_BITS;
    localparam int CLR_BITS = (CLR_A > GLOBAL_HIST_BITS) ? CLR_A : GLOBAL_HIST_BITS;

    // registers
    logic [CLR_BITS-1:0]         clr_cnt_reg, clr_cnt_next;
    logic [PC_INDEX_BITS-1:0]    slot_reg;
    logic                        train_reg;
    logic                        taken_reg;
    logic [LOCAL_HIST_BITS-1:0]  lhist_reg;
    logic [GLOBAL_HIST_BITS-1:0] ghist_reg, ghist_next;
    logic                        fwd_hit_reg, fwd_hit_next;
    logic [LOCAL_HIST_BITS-1:0]  fwd_val_reg;
    logic                        m_tvalid_reg, m_tvalid_next;
    logic [tbp_pkg::M_TDATA_W-1:0] m_tdata_reg;

    // table read data
    logic [LOCAL_HIST_BITS-1:0]  lhist_q;
    logic [1:0]                  lctr_q, gctr_q, ch_q;

    // table write ports
    logic                        lh_we, ctr_we;
    logic [PC_INDEX_BITS-1:0]    lh_waddr, in_slot;
    logic [LOCAL_HIST_BITS-1:0]  lh_wdata, lctr_waddr, lhist_eff, lhist_new;
    logic [GLOBAL_HIST_BITS-1:0] g_waddr, ghist_new;
    logic [1:0]                  lctr_wdata, gctr_wdata, ch_wdata, ch_new;

    // prediction
    logic lguess, gguess, use_g, pred, l_ok, g_ok, wr;

    always_comb begin
        in_slot   = in_pc[PC_INDEX_BITS-1:0];
        // local history written on the same edge as this read is forwarded
        lhist_eff = fwd_hit_reg ? fwd_val_reg : lhist_q;

        lguess = lctr_q[1];
        gguess = gctr_q[1];
        use_g  = ch_q[1];
        pred   = use_g ? gguess : lguess;
        l_ok   = (lguess == taken_reg);
        g_ok   = (gguess == taken_reg);
        ch_new = (g_ok != l_ok) ? tbp_pkg::sat_step(ch_q, g_ok) : ch_q;

        lhist_new = LOCAL_HIST_BITS'({lhist_reg, taken_reg});
        ghist_new = GLOBAL_HIST_BITS'({ghist_reg, taken_reg});
        wr        = cmd.commit && train_reg;
    end

    // write muxes: clearing sweep or training update
    always_comb begin
        lh_we      = cmd.clear || wr;
        ctr_we     = cmd.clear || wr;
        lh_waddr   = cmd.clear ? clr_cnt_reg[PC_INDEX_BITS-1:0] : slot_reg;
        lh_wdata   = cmd.clear ? '0 : lhist_new;
        lctr_waddr = cmd.clear ? clr_cnt_reg[LOCAL_HIST_BITS-1:0] : lhist_reg;
        lctr_wdata = cmd.clear ? tbp_pkg::CTR_STRONG_NT :
                                 tbp_pkg::sat_step(lctr_q, taken_reg);
        g_waddr    = cmd.clear ? clr_cnt_reg[GLOBAL_HIST_BITS-1:0] : ghist_reg;
        gctr_wdata = cmd.clear ? tbp_pkg::CTR_STRONG_NT :
                                 tbp_pkg::sat_step(gctr_q, taken_reg);
        ch_wdata   = cmd.clear ? tbp_pkg::CHOOSER_WEAK_LOCAL : ch_new;
    end

    // next values of control registers
    always_comb begin
        clr_cnt_next  = cmd.clear ? clr_cnt_reg + 1'b1 : clr_cnt_reg;
        ghist_next    = wr ? ghist_new : ghist_reg;
        fwd_hit_next  = cmd.accept ? (wr && (in_slot == slot_reg)) : fwd_hit_reg;
        m_tvalid_next = cmd.commit ? 1'b1 : (m_tready ? 1'b0 : m_tvalid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg  <= '0;
            ghist_reg    <= '0;
            fwd_hit_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            clr_cnt_reg  <= clr_cnt_next;
            ghist_reg    <= ghist_next;
            fwd_hit_reg  <= fwd_hit_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // request capture, lookup and result payload
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            slot_reg    <= in_slot;
            train_reg   <= (in_operation == tbp_pkg::OP_TRAIN);
            taken_reg   <= in_outcome;
            fwd_val_reg <= lhist_new;
        end
        if (cmd.lookup) begin
            lhist_reg <= lhist_eff;
        end
        if (cmd.commit) begin
            m_tdata_reg <= {{(tbp_pkg::M_TDATA_W-4){1'b0}}, gguess, lguess, use_g, pred};
        end
    end

    // tables
    tbp_ram #(.WIDTH(LOCAL_HIST_BITS), .DEPTH(2**PC_INDEX_BITS)) u_lhist_ram (
        .aclk  (aclk),
        .we    (lh_we),
        .waddr (lh_waddr),
        .wdata (lh_wdata),
        .re    (cmd.accept),
        .raddr (in_slot),
        .rdata (lhist_q)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2**LOCAL_HIST_BITS)) u_lctr_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .waddr (lctr_waddr),
        .wdata (lctr_wdata),
        .re    (cmd.lookup),
        .raddr (lhist_eff),
        .rdata (lctr_q)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2**GLOBAL_HIST_BITS)) u_gctr_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .waddr (g_waddr),
        .wdata (gctr_wdata),
        .re    (cmd.lookup),
        .raddr (ghist_reg),
        .rdata (gctr_q)
    );

    tbp_ram #(.WIDTH(2), .DEPTH(2**GLOBAL_HIST_BITS)) u_chooser_ram (
        .aclk  (aclk),
        .we    (ctr_we),
        .waddr (g_waddr),
        .wdata (ch_wdata),
        .re    (cmd.lookup),
        .raddr (ghist_reg),
        .rdata (ch_q)
    );

    // status and outputs
    always_comb begin
        status.clear_last = &clr_cnt_reg;
        status.out_free   = !m_tvalid_reg || m_tready;
        m_tvalid          = m_tvalid_reg;
        m_tdata           = m_tdata_reg;
    end

endmodule

/* design/tournament_branch_predictor.sv */
// Tournament branch predictor top level: stream ports, controller, datapath.
// Depends on tbp_pkg, tbp_ctrl, tbp_dpath (and tbp_ram through the datapath).
//
// Each request gives a branch address, an operation (predict, or predict and
// train) and the real outcome; each request returns one result with the
// chosen prediction, which predictor was chosen, and both guesses, all taken
// from the state before the request. When results are drained promptly, a
// request first reads the per-address local history, then the local
// counter, global counter and chooser tables, after which the result is
// registered and training writes go back as the next request is taken.
// After reset the block runs a clearing pass over
// 2**max(PC_INDEX_BITS, LOCAL_HIST_BITS, GLOBAL_HIST_BITS) table addresses
// (16384 at the defaults) and holds s_tready low until it is done.
module tournament_branch_predictor #(
    parameter int PC_INDEX_BITS    = tbp_pkg::PC_INDEX_BITS_DEF,
    parameter int LOCAL_HIST_BITS  = tbp_pkg::LOCAL_HIST_BITS_DEF,
    parameter int GLOBAL_HIST_BITS = tbp_pkg::GLOBAL_HIST_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tbp_pkg::S_TDATA_W-1:0] s_tdata,  // pc[31:0], outcome[32], pad
    input  logic                          s_tuser,  // operation
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tbp_pkg::M_TDATA_W-1:0] m_tdata   // prediction, used_global,
                                                    // local_guess, global_guess, pad
);

    tbp_pkg::tbp_cmd_t    cmd;
    tbp_pkg::tbp_status_t status;

    tbp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    tbp_dpath #(
        .PC_INDEX_BITS    (PC_INDEX_BITS),
        .LOCAL_HIST_BITS  (LOCAL_HIST_BITS),
        .GLOBAL_HIST_BITS (GLOBAL_HIST_BITS)
    ) u_dpath (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .status       (status),
        .in_operation (s_tuser),
        .in_pc        (s_tdata[tbp_pkg::PC_W-1:0]),
        .in_outcome   (s_tdata[tbp_pkg::PC_W]),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata)
    );

endmodule

/* test/tb_tournament_branch_predictor.sv */
// Self-checking testbench for the tournament branch predictor stream block.
// Holds its own table-based predictor; depends on tbp_pkg and the design RTL.
`timescale 1ns / 100ps

module tb_tournament_branch_predictor;

    localparam int SLOT_BITS    = tbp_pkg::PC_INDEX_BITS_DEF;
    localparam int LHIST_BITS   = tbp_pkg::LOCAL_HIST_BITS_DEF;
    localparam int GHIST_BITS   = tbp_pkg::GLOBAL_HIST_BITS_DEF;
    localparam int RANDOM_ITEMS = 1430;
    localparam int POOL_SIZE    = 8;
    localparam int STALL_LIMIT  = 100000;  // covers the clearing pass after reset
    localparam int DRAIN_CYCLES = 20;
    localparam logic TAKEN      = 1'b1;
    localparam logic NOT_TAKEN  = 1'b0;

    // Result flags in m_tdata order: prediction is bit 0
    typedef struct packed {
        logic global_guess;
        logic local_guess;
        logic used_global;
        logic prediction;
    } guess_t;

    // One directed request; typed rows carry a hand-written expected result
    typedef struct packed {
        logic                     op;
        logic [tbp_pkg::PC_W-1:0] pc;
        logic                     taken;
        logic                     typed;
        guess_t                   want;
    } stim_row_t;

    // typed flag plus result: all counters not taken, local chooser
    localparam logic [4:0] RESET_STATE_GUESS = 5'b1_0000;
    localparam logic [4:0] FROM_PREDICTOR    = 5'b0_0000;

    localparam stim_row_t DIRECTED [21] = '{
        {tbp_pkg::OP_PREDICT, 32'h0000_0000, NOT_TAKEN, RESET_STATE_GUESS},
        {tbp_pkg::OP_PREDICT, 32'hFFFF_FFFF, TAKEN, RESET_STATE_GUESS},  // outcome ignored
        {tbp_pkg::OP_TRAIN,   32'hFFFF_FFFF, TAKEN,     RESET_STATE_GUESS},
        {tbp_pkg::OP_TRAIN,   32'h0000_0000, NOT_TAKEN, FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_PREDICT, 32'hFFFF_D234, NOT_TAKEN, FROM_PREDICTOR},  // same slot
        {tbp_pkg::OP_TRAIN,   32'hFFFF_D234, NOT_TAKEN, FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h8000_0000, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h7FFF_FFFF, NOT_TAKEN, FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h5555_5555, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'hAAAA_AAAA, NOT_TAKEN, FROM_PREDICTOR},
        {tbp_pkg::OP_PREDICT, 32'h0000_1234, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_3FFF, TAKEN,     FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_4000, TAKEN,     FROM_PREDICTOR},  // aliases slot 0
        {tbp_pkg::OP_PREDICT, 32'h0000_0000, NOT_TAKEN, FROM_PREDICTOR},
        {tbp_pkg::OP_TRAIN,   32'h0000_1234, NOT_TAKEN, FROM_PREDICTOR}
    };

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [tbp_pkg::S_TDATA_W-1:0] s_tdata  = '0;
    logic                          s_tuser  = tbp_pkg::OP_PREDICT;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [tbp_pkg::M_TDATA_W-1:0] m_tdata;

    bit steady      = 1'b0;  // no idling on either side while set
    int error_count = 0;
    int stall_cycles = 0;

    // Predictor state
    logic [LHIST_BITS-1:0] addr_history [0:(1 << SLOT_BITS)-1];
    logic [1:0]            local_ctrs   [0:(1 << LHIST_BITS)-1];
    logic [1:0]            global_ctrs  [0:(1 << GHIST_BITS)-1];
    logic [1:0]            choosers     [0:(1 << GHIST_BITS)-1];
    logic [GHIST_BITS-1:0] path_history;
    guess_t                pending_guesses [$];

    // Loop-shaped branches for the random part
    logic [tbp_pkg::PC_W-1:0] pool_pc     [POOL_SIZE];
    int                       pool_period [POOL_SIZE];
    int                       pool_trips  [POOL_SIZE];

    tournament_branch_predictor u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // 2-bit saturating move toward taken / global (up) or the other way
    function automatic logic [1:0] saturate_toward(logic [1:0] ctr, logic up);
        if (up)
            return (ctr == 2'd3) ? ctr : ctr + 2'd1;
        return (ctr == 2'd0) ? ctr : ctr - 2'd1;
    endfunction

    // Guesses from the current tables, then training when asked
    function automatic guess_t predict_and_train(logic op, logic [tbp_pkg::PC_W-1:0] pc,
                                                 logic taken);
        logic [SLOT_BITS-1:0]  slot;
        logic [LHIST_BITS-1:0] lh;
        logic [GHIST_BITS-1:0] gh;
        logic [1:0]            lc, gc, ch;
        guess_t                g;
        slot = pc[SLOT_BITS-1:0];
        lh   = addr_history[slot];
        gh   = path_history;
        lc   = local_ctrs[lh];
        gc   = global_ctrs[gh];
        ch   = choosers[gh];
        g.local_guess  = lc[1];
        g.global_guess = gc[1];
        g.used_global  = ch[1];
        g.prediction   = ch[1] ? gc[1] : lc[1];
        if (op == tbp_pkg::OP_TRAIN) begin
            // chooser leans toward whichever side alone was right
            if ((g.local_guess == taken) != (g.global_guess == taken))
                choosers[gh] = saturate_toward(ch, g.global_guess == taken);
            global_ctrs[gh]    = saturate_toward(gc, taken);
            local_ctrs[lh]     = saturate_toward(lc, taken);
            addr_history[slot] = {lh[LHIST_BITS-2:0], taken};
            path_history       = {gh[GHIST_BITS-2:0], taken};
        end
        return g;
    endfunction

    // Present one request, wait for the handshake, queue its expected result
    task automatic send_request(logic op, logic [tbp_pkg::PC_W-1:0] pc, logic taken,
                                logic typed, guess_t want);
        guess_t model;
        if (!steady && $urandom_range(0, 99) < 25) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(tbp_pkg::S_TDATA_W-tbp_pkg::PC_W-1){1'b0}}, taken, pc};
        do @(posedge aclk); while (!s_tready);
        model = predict_and_train(op, pc, taken);
        pending_guesses.push_back(typed ? want : model);
    endtask

    // Fresh set of loop branches with random slots and trip counts
    task automatic refill_pool();
        for (int p = 0; p < POOL_SIZE; p++) begin
            pool_pc[p]     = $urandom_range(0, (1 << SLOT_BITS) - 1);
            pool_period[p] = (p == 0) ? 1 : $urandom_range(2, 7);
            pool_trips[p]  = 0;
        end
    endtask

    // Result side stalls
    always @(posedge aclk)
        m_tready <= steady || ($urandom_range(0, 99) >= 25);

    // Compare each result against the oldest expectation
    always @(posedge aclk) begin : result_check
        guess_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = guess_t'(m_tdata[3:0]);
            if (pending_guesses.size() == 0) begin
                $error("result 0x%h with no request outstanding", m_tdata);
                error_count++;
            end else begin
                want = pending_guesses.pop_front();
                if (got.prediction !== want.prediction) begin
                    $error("prediction: expected %0d, got %0d", want.prediction, got.prediction);
                    error_count++;
                end
                if (got.used_global !== want.used_global) begin
                    $error("used_global: expected %0d, got %0d", want.used_global,
                           got.used_global);
                    error_count++;
                end
                if (got.local_guess !== want.local_guess) begin
                    $error("local_guess: expected %0d, got %0d", want.local_guess,
                           got.local_guess);
                    error_count++;
                end
                if (got.global_guess !== want.global_guess) begin
                    $error("global_guess: expected %0d, got %0d", want.global_guess,
                           got.global_guess);
                    error_count++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("tb_tournament_branch_predictor: errors");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int                       n, k, kind;
        logic [tbp_pkg::PC_W-1:0] pc;
        logic                     taken;
        stim_row_t                row;

        // predictor reset state
        for (int i = 0; i < (1 << SLOT_BITS); i++) addr_history[i] = '0;
        for (int i = 0; i < (1 << LHIST_BITS); i++) local_ctrs[i] = tbp_pkg::CTR_STRONG_NT;
        for (int i = 0; i < (1 << GHIST_BITS); i++) begin
            global_ctrs[i] = tbp_pkg::CTR_STRONG_NT;
            choosers[i]    = tbp_pkg::CHOOSER_WEAK_LOCAL;
        end
        path_history = '0;

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed requests
        for (n = 0; n < $size(DIRECTED); n++) begin
            row = DIRECTED[n];
            send_request(row.op, row.pc, row.taken, row.typed, row.want);
        end

        // random part: mostly trained loop branches, some lookups and noise
        k = 0;
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 500 && n < 800);
            if (n % 300 == 0)
                refill_pool();
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                k = ($urandom_range(0, 99) < 75) ? (k + 1) % POOL_SIZE
                                                 : $urandom_range(0, POOL_SIZE - 1);
                pc    = ($urandom() & ~((1 << SLOT_BITS) - 1)) | pool_pc[k];
                taken = (pool_period[k] == 1) ||
                        ((pool_trips[k] % pool_period[k]) != pool_period[k] - 1);
                pool_trips[k]++;
                send_request(tbp_pkg::OP_TRAIN, pc, taken, 1'b0, '0);
            end else if (kind < 85) begin
                pc = $urandom_range(0, 1) ? $urandom()
                                          : pool_pc[$urandom_range(0, POOL_SIZE - 1)];
                send_request(tbp_pkg::OP_PREDICT, pc, $urandom_range(0, 1), 1'b0, '0);
            end else begin
                send_request(tbp_pkg::OP_TRAIN, $urandom(), $urandom_range(0, 1), 1'b0, '0);
            end
        end
        steady = 1'b0;
        s_tvalid <= 1'b0;

        // drain, then allow the pipeline to settle
        while (pending_guesses.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("tb_tournament_branch_predictor: clean");
        else
            $display("tb_tournament_branch_predictor: errors");
        $finish;
    end

endmodule

/* files.f */
design/tbp_pkg.sv
design/tbp_ram.sv
design/tbp_ctrl.sv
design/tbp_dpath.sv
design/tournament_branch_predictor.sv
test/tb_tournament_branch_predictor.sv
